### sv/hbu_pkg.sv
// Shared types and constants for the hex text bitmap unpacker.
package hbu_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned RES_DEPTH     = 4;
  localparam int unsigned RES_PTR_W     = 2;
  localparam int unsigned RES_CNT_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_BYTE     = 2'd0,
    MODE_WORD     = 2'd1,
    MODE_WORD_REV = 2'd2,
    MODE_SPARE    = 2'd3
  } mode_e;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_done;
    logic       input_error;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  function automatic logic [15:0] reverse16(input logic [15:0] s);
    logic [15:0] d;
    for (int n = 0; n < 16; n++) begin
      d[15-n] = s[n];
    end
    return d;
  endfunction

endpackage

### sv/hex_text_bitmap_unpacker.sv
// Hex text bitmap unpacker: token parser, row counters and result queue.
//
//   channel | direction | handshake                   | payload
//   in      | input     | in_valid_i / in_stall_o     | char_code_i, end_of_input_i
//   out     | output    | out_valid_o / out_stall_i   | data_byte_o, image_done_o,
//           |           |                             | input_error_o
//   cfg     | input     | cfg_we_i, cfg_idx_i         | cfg_data_i
//
// One character is taken per cycle; parsing and row counting settle in that cycle and
// the bytes go into a four-entry result queue, visible on the next cycle.
// A word token gives two bytes but takes at least two characters, so a free output
// keeps pace with one character per cycle; only output stalls hold the input back.
// in_stall_o rises while the queue has room for fewer than two bytes.
// rst_ni clears the parser state and the queue, and loads the register defaults.
module hex_text_bitmap_unpacker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hbu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hbu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     char_code_i,
  input  logic                           end_of_input_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     data_byte_o,
  output logic                           image_done_o,
  output logic                           input_error_o
);
  import hbu_pkg::*;

  logic [1:0]       mode_q;
  logic [DIM_W-1:0] width_q, height_q;

  logic [15:0]      tok_q, tok_d;
  logic             have_q, have_d;
  logic [DIM_W-1:0] tin_q, tin_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic             fin_q, fin_d;

  res_t                 res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q;

  logic             acc, pop;
  logic [1:0]       push_n;
  res_t             res0, res1;
  logic             is_digit, is_delim;
  logic [3:0]       dig;
  logic [DIM_W-1:0] w, h, per_row, tin_inc, row_inc;
  logic [DIM_W:0]   w_ext;
  logic             word_mode, last_row_tok, done, pad;
  logic [15:0]      val;

  assign in_stall_o    = (cnt_q > RES_CNT_W'(2));
  assign acc           = in_valid_i && !in_stall_o;
  assign out_valid_o   = (cnt_q != '0);
  assign pop           = out_valid_o && !out_stall_i;
  assign data_byte_o   = res_q[rd_ptr_q].data_byte;
  assign image_done_o  = res_q[rd_ptr_q].image_done;
  assign input_error_o = res_q[rd_ptr_q].input_error;

  // classify the character
  always_comb begin
    is_digit = 1'b0;
    dig      = 4'd0;
    if (char_code_i >= CH_0 && char_code_i <= CH_9) begin
      is_digit = 1'b1;
      dig      = 4'(char_code_i - CH_0);
    end else if (char_code_i >= CH_UA && char_code_i <= CH_UF) begin
      is_digit = 1'b1;
      dig      = 4'(char_code_i - CH_UA + 8'd10);
    end else if (char_code_i >= CH_LA && char_code_i <= CH_LF) begin
      is_digit = 1'b1;
      dig      = 4'(char_code_i - CH_LA + 8'd10);
    end
    is_delim = (char_code_i == CH_SPACE) || (char_code_i == CH_COMMA) ||
               (char_code_i == CH_RBRACE) || (char_code_i == CH_NL) ||
               (char_code_i == CH_TAB);
  end

  always_comb begin
    w         = clamp_dim(width_q);
    h         = clamp_dim(height_q);
    word_mode = (mode_q == MODE_WORD) || (mode_q == MODE_WORD_REV);
    w_ext     = {1'b0, w};
    if (word_mode) begin
      per_row = DIM_W'((w_ext + (DIM_W+1)'(15)) >> 4);
    end else begin
      per_row = DIM_W'((w_ext + (DIM_W+1)'(7)) >> 3);
    end
    tin_inc      = tin_q + DIM_W'(1);
    row_inc      = row_q + DIM_W'(1);
    last_row_tok = (tin_inc >= per_row);
    done         = last_row_tok && (row_inc >= h);
    pad          = (w[3:0] != 4'd0) && (w[3:0] < 4'd9);
    val          = (mode_q == MODE_WORD_REV) ? reverse16(tok_q) : tok_q;

    tok_d  = tok_q;
    have_d = have_q;
    tin_d  = tin_q;
    row_d  = row_q;
    fin_d  = fin_q;
    push_n = 2'd0;
    res0   = '0;
    res1   = '0;

    if (acc && !fin_q) begin
      if (end_of_input_i) begin
        fin_d  = 1'b1;
        tok_d  = '0;
        have_d = 1'b0;
        push_n = 2'd1;
        res0   = '{data_byte: 8'h00, image_done: 1'b0, input_error: 1'b1};
      end else if (is_digit) begin
        tok_d  = {tok_q[11:0], dig};
        have_d = 1'b1;
      end else if (is_delim && have_q) begin
        tok_d  = '0;
        have_d = 1'b0;
        if (last_row_tok) begin
          tin_d = '0;
          row_d = row_inc;
        end else begin
          tin_d = tin_inc;
        end
        if (done) begin
          fin_d = 1'b1;
        end
        if (!word_mode) begin
          push_n = 2'd1;
          res0   = '{data_byte: tok_q[7:0], image_done: done, input_error: 1'b0};
        end else if (pad && last_row_tok) begin
          push_n = 2'd1;
          res0   = '{data_byte: val[7:0], image_done: done, input_error: 1'b0};
        end else begin
          push_n = 2'd2;
          res0   = '{data_byte: val[7:0], image_done: 1'b0, input_error: 1'b0};
          res1   = '{data_byte: val[15:8], image_done: done, input_error: 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BYTE;
      width_q  <= DIM_W'(16);
      height_q <= DIM_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FORMAT_MODE:  mode_q   <= cfg_data_i[1:0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      have_q   <= 1'b0;
      tin_q    <= '0;
      row_q    <= '0;
      fin_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      tok_q    <= tok_d;
      have_q   <= have_d;
      tin_q    <= tin_d;
      row_q    <= row_d;
      fin_q    <= fin_d;
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
      cnt_q    <= cnt_q + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      res_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      res_q[wr_ptr_q + RES_PTR_W'(1)] <= res1;
    end
  end

endmodule

### bench/hex_text_bitmap_unpacker_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the hex text bitmap unpacker: one image parsed under changing formats.
module hex_text_bitmap_unpacker_tb;
  import hbu_pkg::*;

  localparam logic [4:0] KIND_DELIM  = 5'd16;
  localparam logic [4:0] KIND_OTHER  = 5'd17;
  localparam logic [7:0] CH_LX       = 8'h78;
  localparam logic [7:0] CH_CODE_MAX = 8'hff;
  localparam int unsigned MAX_HOLD   = 17;
  localparam int unsigned SETTLE_CYC = 4;
  localparam int unsigned DRAIN_CYC  = 40;
  localparam int unsigned PHASE_CHARS = 110;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            char_code_i;
  logic                  end_of_input_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            data_byte_o;
  logic                  image_done_o;
  logic                  input_error_o;

  mode_e            fmt_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [15:0]      tok_acc;
  bit               tok_open;
  logic [DIM_W-1:0] row_tokens;
  logic [DIM_W-1:0] rows_done;
  bit               img_closed;

  res_t        pending_bytes[$];
  int unsigned mismatches;
  int unsigned chars_sent;
  int unsigned out_hold;
  bit          in_quiet;
  bit          out_quiet;

  hex_text_bitmap_unpacker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .image_done_o   (image_done_o),
    .input_error_o  (input_error_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [4:0] char_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_OTHER;
    if (c >= CH_0 && c <= CH_9) begin
      k = 5'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      k = 5'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LF) begin
      k = 5'(c - CH_LA + 8'd10);
    end else if (c == CH_SPACE || c == CH_COMMA || c == CH_RBRACE || c == CH_NL ||
                 c == CH_TAB) begin
      k = KIND_DELIM;
    end
    return k;
  endfunction

  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  function automatic logic [15:0] mirror16(input logic [15:0] s);
    logic [15:0] d;
    int          n;
    for (n = 0; n < 16; n++) begin
      d[n] = s[15-n];
    end
    return d;
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic done,
                                      input logic err);
    res_t r;
    r.data_byte   = b;
    r.image_done  = done;
    r.input_error = err;
    pending_bytes.push_back(r);
  endfunction

  function automatic void unpack_char(input logic [7:0] c, input logic eoi);
    logic [4:0]       kind;
    logic [15:0]      val;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] per_row;
    bit               words;
    bit               row_end;
    bit               fin;
    bit               short_row;
    if (img_closed) begin
      return;
    end
    if (eoi) begin
      img_closed = 1'b1;
      tok_acc    = '0;
      tok_open   = 1'b0;
      expect_byte(8'h00, 1'b0, 1'b1);
      return;
    end
    kind = char_kind(c);
    if (kind < KIND_DELIM) begin
      tok_acc  = {tok_acc[11:0], kind[3:0]};
      tok_open = 1'b1;
      return;
    end
    if (kind == KIND_OTHER || !tok_open) begin
      return;
    end
    val      = tok_acc;
    tok_acc  = '0;
    tok_open = 1'b0;
    w        = effective_dim(width_reg);
    h        = effective_dim(height_reg);
    words    = (fmt_reg == MODE_WORD || fmt_reg == MODE_WORD_REV);
    per_row  = words ? ((w + DIM_W'(15)) >> 4) : ((w + DIM_W'(7)) >> 3);
    row_tokens = row_tokens + DIM_W'(1);
    row_end    = (row_tokens >= per_row);
    if (row_end) begin
      row_tokens = '0;
      rows_done  = rows_done + DIM_W'(1);
    end
    fin = row_end && (rows_done >= h);
    if (fin) begin
      img_closed = 1'b1;
    end
    if (!words) begin
      expect_byte(val[7:0], fin, 1'b0);
      return;
    end
    if (fmt_reg == MODE_WORD_REV) begin
      val = mirror16(val);
    end
    short_row = (w[3:0] != 4'd0) && (w[3:0] < 4'd9);
    if (short_row && row_end) begin
      expect_byte(val[7:0], fin, 1'b0);
    end else begin
      expect_byte(val[7:0], 1'b0, 1'b0);
      expect_byte(val[15:8], fin, 1'b0);
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_0 + 8'(nib);
    end else begin
      c = (upper ? CH_UA : CH_LA) + 8'(nib) - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_delim();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = CH_SPACE;
      1: c = CH_COMMA;
      2: c = CH_RBRACE;
      3: c = CH_NL;
      default: c = CH_TAB;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (char_kind(c) != KIND_OTHER) begin
      c = 8'($urandom);
    end
    return c;
  endfunction

  task automatic put_char(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_HOLD);
    if ($urandom_range(0, 49) == 0) begin
      in_quiet = !in_quiet;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    unpack_char(c, eoi);
  endtask

  task automatic put_token(input logic [23:0] v, input int unsigned ndig, input bit prefix,
                           input bit noisy);
    int i;
    if (prefix) begin
      put_char(CH_0, 1'b0);
      put_char($urandom_range(0, 1) ? CH_LX : (CH_LX - 8'h20), 1'b0);
    end
    for (i = int'(ndig) - 1; i >= 0; i--) begin
      put_char(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))), 1'b0);
      if (noisy && $urandom_range(0, 2) == 0) begin
        put_char(noise_char(), 1'b0);
      end
    end
    put_char(pick_delim(), 1'b0);
  endtask

  task automatic put_random_token();
    int unsigned ndig;
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    put_token(24'($urandom), ndig, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apply_setting(input mode_e m, input logic [DIM_W-1:0] w,
                               input logic [DIM_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FORMAT_MODE;
    cfg_data_i <= {11'($urandom), m};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UNUSED;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fmt_reg    = m;
    width_reg  = w;
    height_reg = h;
  endtask

  task automatic test_reset_defaults();
    put_token(24'h00, 2, 1'b1, 1'b0);
    put_token(24'hFF, 2, 1'b0, 1'b0);
    put_char(CH_CODE_MAX, 1'b0);
    put_char(8'h00, 1'b0);
    put_char(CH_SPACE, 1'b0);
    put_token(24'hA5, 2, 1'b0, 1'b0);
  endtask

  task automatic test_format_modes();
    settle();
    apply_setting(MODE_WORD, DIM_W'(0), DIM_W'(8191));
    put_token(24'h12345, 5, 1'b0, 1'b0);
    settle();
    apply_setting(MODE_WORD_REV, DIM_W'(4096), DIM_W'(4096));
    put_token(24'h8001, 4, 1'b0, 1'b0);
    settle();
    apply_setting(MODE_SPARE, DIM_W'(9), DIM_W'(4096));
    put_token(24'h7E, 2, 1'b0, 1'b0);
  endtask

  task automatic test_random_formats();
    int               p;
    int unsigned      stop_at;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: w = DIM_W'(8191);
        1: w = DIM_W'(1);
        2: w = DIM_W'(4096);
        3: w = DIM_W'(0);
        4: w = DIM_W'(24);
        5: w = DIM_W'(9);
        6: w = DIM_W'(17);
        default: w = DIM_W'($urandom_range(1, 300));
      endcase
      h = (p == 0) ? DIM_W'(4096) : DIM_W'($urandom_range(2048, 8191));
      settle();
      apply_setting(mode_e'(2'(p)), w, h);
      stop_at = chars_sent + PHASE_CHARS;
      while (chars_sent < stop_at) begin
        case ($urandom_range(0, 9))
          0: put_char(noise_char(), 1'b0);
          1: put_char(pick_delim(), 1'b0);
          default: put_random_token();
        endcase
      end
    end
  endtask

  task automatic test_image_end();
    settle();
    apply_setting(mode_e'(2'($urandom_range(0, 3))), DIM_W'($urandom_range(0, 40)),
                  DIM_W'(0));
    if ($urandom_range(0, 1)) begin
      while (!img_closed) begin
        put_random_token();
      end
    end else begin
      put_char(hex_char(4'($urandom), 1'b1), 1'b0);
      put_char(hex_char(4'($urandom), 1'b0), 1'b0);
      put_char(noise_char(), 1'b1);
    end
  endtask

  task automatic test_after_finish();
    settle();
    put_random_token();
    put_char(noise_char(), 1'b1);
    put_random_token();
    put_char(8'($urandom), 1'b1);
    put_random_token();
  endtask

  always @(posedge clk_i) begin
    res_t r;
    if (!rst_ni) begin
      out_hold = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected word: data_byte %0h image_done %0b input_error %0b",
                 data_byte_o, image_done_o, input_error_o);
          mismatches++;
        end else begin
          r = pending_bytes.pop_front();
          if (data_byte_o !== r.data_byte) begin
            $error("data_byte expected %0h actual %0h", r.data_byte, data_byte_o);
            mismatches++;
          end
          if (image_done_o !== r.image_done) begin
            $error("image_done expected %0b actual %0b", r.image_done, image_done_o);
            mismatches++;
          end
          if (input_error_o !== r.input_error) begin
            $error("input_error expected %0b actual %0b", r.input_error, input_error_o);
            mismatches++;
          end
        end
        out_hold = out_quiet ? 0 : $urandom_range(0, MAX_HOLD);
        if ($urandom_range(0, 39) == 0) begin
          out_quiet = !out_quiet;
        end
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_FORMAT_MODE;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    char_code_i    <= '0;
    end_of_input_i <= 1'b0;
    fmt_reg    = MODE_BYTE;
    width_reg  = DIM_W'(16);
    height_reg = DIM_W'(16);
    tok_acc    = '0;
    tok_open   = 1'b0;
    row_tokens = '0;
    rows_done  = '0;
    img_closed = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_format_modes();
    test_random_formats();
    test_image_end();
    test_after_finish();
    settle();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("hex_text_bitmap_unpacker_tb OK");
    end else begin
      $display("hex_text_bitmap_unpacker_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("hex_text_bitmap_unpacker_tb NOT OK");
    $finish;
  end

endmodule

### files.f
sv/hbu_pkg.sv
sv/hex_text_bitmap_unpacker.sv
bench/hex_text_bitmap_unpacker_tb.sv
